[hw/rtl/lr_pkg.sv]
// ----------------------------------------------------------------------------
// lr_pkg
// Shared types and constants of the line rasterizer: coordinate widths,
// opcodes, register indexes and the command passed from front to back.
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int CoordBits     = 12;
  localparam int WinBits       = 12;
  localparam int ErrBits       = CoordBits + 3;
  localparam int CfgIdxBits    = 1;
  localparam int QueueDepth    = 4;
  localparam int QueuePtrBits  = $clog2(QueueDepth);
  localparam int QueueCntBits  = $clog2(QueueDepth + 1);

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [ErrBits-1:0]   err_t;
  typedef logic [WinBits-1:0]          win_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } lr_op_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_WINDOW_WIDTH  = 1'b0,
    CFG_WINDOW_HEIGHT = 1'b1
  } lr_cfg_e;

  typedef enum logic [1:0] {
    CMD_DROP = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_STEP = 2'd2
  } lr_kind_e;

  typedef struct packed {
    lr_kind_e kind;
    coord_t   col;
    coord_t   row;
    coord_t   major_end;
    err_t     err;
    err_t     inc_keep;
    err_t     inc_move;
    logic     minor_negative;
    logic     x_is_major;
    logic     single;
  } lr_cmd_t;

  typedef struct packed {
    win_t width;
    win_t height;
  } lr_win_t;

endpackage

[hw/rtl/lr_front.sv]
// ----------------------------------------------------------------------------
// lr_front
// Classifies input items and sets up a line on load: deltas, major axis,
// start endpoint, initial error and the two error increments.
// ----------------------------------------------------------------------------
module lr_front (
  input  logic                     opcode_i,
  input  logic [lr_pkg::CoordBits-1:0] start_x_i,
  input  logic [lr_pkg::CoordBits-1:0] start_y_i,
  input  logic [lr_pkg::CoordBits-1:0] end_x_i,
  input  logic [lr_pkg::CoordBits-1:0] end_y_i,
  input  logic                     start_visible_i,
  input  logic                     end_visible_i,
  output lr_pkg::lr_cmd_t          cmd_o
);
  import lr_pkg::*;

  logic signed [CoordBits:0] dx, dy;
  logic [CoordBits-1:0]      adx, ady;
  logic [CoordBits-1:0]      a_major, a_minor;
  logic                      x_major;
  logic                      swap;
  coord_t                    sx, sy, ex, ey;
  coord_t                    start_major;

  always_comb begin
    sx = coord_t'(start_x_i);
    sy = coord_t'(start_y_i);
    ex = coord_t'(end_x_i);
    ey = coord_t'(end_y_i);
    dx = $signed({ex[CoordBits-1], ex}) - $signed({sx[CoordBits-1], sx});
    dy = $signed({ey[CoordBits-1], ey}) - $signed({sy[CoordBits-1], sy});
    adx = dx[CoordBits] ? CoordBits'(-dx) : dx[CoordBits-1:0];
    ady = dy[CoordBits] ? CoordBits'(-dy) : dy[CoordBits-1:0];
    x_major = (ady <= adx);
    a_major = x_major ? adx : ady;
    a_minor = x_major ? ady : adx;
    swap = x_major ? (ex < sx) : (ey < sy);

    cmd_o.kind = CMD_STEP;
    if (opcode_i == OP_LOAD) begin
      cmd_o.kind = (start_visible_i && end_visible_i) ? CMD_LOAD : CMD_DROP;
    end
    cmd_o.col = swap ? ex : sx;
    cmd_o.row = swap ? ey : sy;
    if (x_major) begin
      cmd_o.major_end = swap ? sx : ex;
      start_major     = cmd_o.col;
    end else begin
      cmd_o.major_end = swap ? sy : ey;
      start_major     = cmd_o.row;
    end
    cmd_o.single   = (start_major == cmd_o.major_end);
    cmd_o.err      = err_t'({a_minor, 1'b0}) - err_t'(a_major);
    cmd_o.inc_keep = err_t'({a_minor, 1'b0});
    cmd_o.inc_move = err_t'({a_minor, 1'b0}) - err_t'({a_major, 1'b0});
    cmd_o.minor_negative = !((dx[CoordBits] && dy[CoordBits]) ||
                             (!dx[CoordBits] && (dx != '0) &&
                              !dy[CoordBits] && (dy != '0)));
    cmd_o.x_is_major = x_major;
  end

endmodule

[hw/rtl/lr_queue.sv]
// ----------------------------------------------------------------------------
// lr_queue
// Short command queue between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
module lr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lr_pkg::lr_cmd_t  cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output lr_pkg::lr_cmd_t  cmd_o
);
  import lr_pkg::*;

  lr_cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntBits-1:0] count_q, count_d;
  logic                    do_push, do_pop;

  assign full_o  = (count_q == QueueCntBits'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[hw/rtl/lr_back.sv]
// ----------------------------------------------------------------------------
// lr_back
// Holds the line state, walks the line one pixel per command and keeps
// the result in an output register.
// ----------------------------------------------------------------------------
module lr_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lr_pkg::lr_win_t              win_i,
  input  logic                         cmd_valid_i,
  input  lr_pkg::lr_cmd_t              cmd_i,
  output logic                         cmd_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lr_pkg::CoordBits-1:0] pixel_x_o,
  output logic [lr_pkg::CoordBits-1:0] pixel_y_o,
  output logic                         pixel_valid_o,
  output logic                         on_screen_o,
  output logic                         last_o
);
  import lr_pkg::*;

  coord_t col_q, col_d, row_q, row_d, major_end_q, major_end_d;
  err_t   err_q, err_d, inc_keep_q, inc_keep_d, inc_move_q, inc_move_d;
  logic   minor_neg_q, minor_neg_d, x_major_q, x_major_d;
  logic   active_q, active_d;

  logic   out_valid_q;
  coord_t px_q, px_d, py_q, py_d;
  logic   pvalid_q, pvalid_d, on_q, on_d, last_q, last_d;

  coord_t step;
  logic   keep;
  logic   last;

  assign cmd_pop_o = cmd_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    major_end_d = major_end_q;
    err_d       = err_q;
    inc_keep_d  = inc_keep_q;
    inc_move_d  = inc_move_q;
    minor_neg_d = minor_neg_q;
    x_major_d   = x_major_q;
    active_d    = active_q;
    step        = minor_neg_q ? '1 : coord_t'(1);
    keep        = x_major_q ? err_q[ErrBits-1] : (err_q[ErrBits-1] || (err_q == '0));
    last        = 1'b1;
    pvalid_d    = 1'b0;

    case (cmd_i.kind)
      CMD_DROP: begin
        active_d = 1'b0;
      end
      CMD_LOAD: begin
        col_d       = cmd_i.col;
        row_d       = cmd_i.row;
        major_end_d = cmd_i.major_end;
        err_d       = cmd_i.err;
        inc_keep_d  = cmd_i.inc_keep;
        inc_move_d  = cmd_i.inc_move;
        minor_neg_d = cmd_i.minor_negative;
        x_major_d   = cmd_i.x_is_major;
        last        = cmd_i.single;
        active_d    = !cmd_i.single;
        pvalid_d    = 1'b1;
      end
      CMD_STEP: begin
        if (active_q) begin
          if (x_major_q) begin
            col_d = col_q + coord_t'(1);
            if (!keep) begin
              row_d = row_q + step;
            end
            last = (col_d >= major_end_q);
          end else begin
            row_d = row_q + coord_t'(1);
            if (!keep) begin
              col_d = col_q + step;
            end
            last = (row_d >= major_end_q);
          end
          err_d    = err_q + (keep ? inc_keep_q : inc_move_q);
          active_d = !last;
          pvalid_d = 1'b1;
        end
      end
      default: begin
        active_d = active_q;
      end
    endcase

    px_d   = pvalid_d ? col_d : '0;
    py_d   = pvalid_d ? row_d : '0;
    last_d = last;
    on_d   = pvalid_d && !col_d[CoordBits-1] && !row_d[CoordBits-1] &&
             (WinBits'(col_d[CoordBits-2:0]) < win_i.width) &&
             (WinBits'(row_d[CoordBits-2:0]) < win_i.height);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      major_end_q <= '0;
      err_q       <= '0;
      inc_keep_q  <= '0;
      inc_move_q  <= '0;
      minor_neg_q <= 1'b0;
      x_major_q   <= 1'b0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        col_q       <= col_d;
        row_q       <= row_d;
        major_end_q <= major_end_d;
        err_q       <= err_d;
        inc_keep_q  <= inc_keep_d;
        inc_move_q  <= inc_move_d;
        minor_neg_q <= minor_neg_d;
        x_major_q   <= x_major_d;
        active_q    <= active_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      px_q     <= px_d;
      py_q     <= py_d;
      pvalid_q <= pvalid_d;
      on_q     <= on_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_valid_o = pvalid_q;
  assign on_screen_o   = on_q;
  assign last_o        = last_q;

endmodule

[hw/rtl/line_rasterizer.sv]
// ----------------------------------------------------------------------------
// line_rasterizer
// Bresenham line generator, one result item per input item.
//
// Input channel (in_valid_i / in_stall_o): opcode 0 loads a line from two
// signed endpoints and returns its first pixel; opcode 1 returns the next
// pixel. A load with an invisible endpoint, or a step with no line in
// progress, returns an empty item (pixel_valid 0, last 1).
// Output channel (out_valid_o / out_stall_i): pixel position, on-screen
// flag against the window registers, and a last marker.
// Config port: cfg_we_i writes window width (index 0) or height (index 1).
// An accepted item is written into the command queue, then into the back-end
// output register. Throughput is one item per cycle while the receiver does
// not stall. A 4-entry command queue separates the front-end setup from the
// walker, so the input keeps accepting items while a result waits on a
// stalled receiver; in_stall_o rises only once that queue is full.
// Reset empties the queue, drops any line in progress and sets the window
// to 1920 x 1080.
// ----------------------------------------------------------------------------
module line_rasterizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lr_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [lr_pkg::WinBits-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [lr_pkg::CoordBits-1:0]  start_x_i,
  input  logic [lr_pkg::CoordBits-1:0]  start_y_i,
  input  logic [lr_pkg::CoordBits-1:0]  end_x_i,
  input  logic [lr_pkg::CoordBits-1:0]  end_y_i,
  input  logic                          start_visible_i,
  input  logic                          end_visible_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lr_pkg::CoordBits-1:0]  pixel_x_o,
  output logic [lr_pkg::CoordBits-1:0]  pixel_y_o,
  output logic                          pixel_valid_o,
  output logic                          on_screen_o,
  output logic                          last_o
);
  import lr_pkg::*;

  lr_win_t win_q;
  lr_cmd_t front_cmd, head_cmd;
  logic    q_full, q_valid, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q.width  <= WinBits'(1920);
      win_q.height <= WinBits'(1080);
    end else if (cfg_we_i) begin
      case (lr_cfg_e'(cfg_index_i))
        CFG_WINDOW_WIDTH:  win_q.width  <= cfg_wdata_i;
        CFG_WINDOW_HEIGHT: win_q.height <= cfg_wdata_i;
        default:           win_q        <= win_q;
      endcase
    end
  end

  assign in_stall_o = q_full;

  lr_front u_front (
    .opcode_i        (opcode_i),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .end_x_i         (end_x_i),
    .end_y_i         (end_y_i),
    .start_visible_i (start_visible_i),
    .end_visible_i   (end_visible_i),
    .cmd_o           (front_cmd)
  );

  lr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  lr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .win_i         (win_q),
    .cmd_valid_i   (q_valid),
    .cmd_i         (head_cmd),
    .cmd_pop_o     (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_valid_o (pixel_valid_o),
    .on_screen_o   (on_screen_o),
    .last_o        (last_o)
  );

endmodule
